/* rtl/itcs_pkg.sv */
// Shared constants and register map for the index-to-candidate-string block.
package itcs_pkg;

    localparam int MAX_LEN   = 16;
    localparam int LEN_W     = 5;
    localparam int POS_W     = $clog2(MAX_LEN);
    localparam int SYM_W     = 6;
    localparam int RADIX_W   = 7;
    localparam int CODE_W    = 64;
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = CODE_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int ADDR_W    = 4;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 7'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 7'd64;
    localparam logic [LEN_W-1:0]   LEN_CAP   = LEN_W'(MAX_LEN);

    localparam logic [1:0] REG_ALPHABET_SIZE = 2'd0;
    localparam logic [1:0] REG_MIN_LEN       = 2'd1;
    localparam logic [1:0] REG_MAX_LEN       = 2'd2;

    typedef logic [LEN_W-1:0] len_t;

endpackage

/* rtl/index_to_candidate_string.sv */
// Index to candidate string converter: length search, radix conversion, digit output.
//
// Each 64-bit code on the slave stream is turned into its candidate string, one master
// request per base-B digit (most significant first, tlast on the final digit), or into a
// single error request with tuser set when the code is at or past the total string count.
// Radix and length range come from the APB registers and are sampled when a code is taken.
// One code at a time: s_tready is high only while the block is idle. A code of length L
// is handled in steps: repeated multiplication forms B^min_len, compare-subtract chooses L,
// radix division yields the L digits (one shared divider, 8 quotient bits per cycle),
// and the L digits go out as master requests, each held while the sink stalls.
module index_to_candidate_string
(
    input  logic                           clk,
    input  logic                           rst_n,
    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [itcs_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // code stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [63:0]                    s_tdata,   // [63:0] code
    // symbol stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,   // [5:0] symbol_index, [9:6] position,
                                                      // [14:10] string_length, [15] zero
    output logic                           m_tlast,   // is_last
    output logic                           m_tuser    // out_of_range
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_POW  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    localparam int PROD_W = itcs_pkg::CODE_W + itcs_pkg::RADIX_W;

    // configuration registers
    logic [itcs_pkg::RADIX_W-1:0] alphabet_size_reg;
    itcs_pkg::len_t               min_len_reg;
    itcs_pkg::len_t               max_len_reg;

    // sequencer and datapath
    logic [2:0]                     state_reg, state_next;
    logic [itcs_pkg::RADIX_W-1:0]   b_reg, b_next;
    itcs_pkg::len_t                 lo_reg, lo_next;
    itcs_pkg::len_t                 hi_reg, hi_next;
    itcs_pkg::len_t                 l_reg, l_next;
    itcs_pkg::len_t                 len_reg, len_next;
    logic [itcs_pkg::CODE_W-1:0]    r_reg, r_next;
    logic [itcs_pkg::CODE_W-1:0]    pw_reg, pw_next;
    logic                           big_reg, big_next;
    logic                           err_reg, err_next;
    logic [itcs_pkg::RADIX_W-1:0]   rem_reg, rem_next;
    logic [itcs_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [itcs_pkg::POS_W-1:0]     dcnt_reg, dcnt_next;
    logic [itcs_pkg::POS_W-1:0]     ocnt_reg, ocnt_next;

    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [15:0]                    m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;
    logic                           m_tuser_reg, m_tuser_next;

    // digit buffer, filled least significant digit first
    logic [itcs_pkg::SYM_W-1:0]     digits [itcs_pkg::MAX_LEN];
    logic                           dig_we;
    logic [itcs_pkg::POS_W-1:0]     dig_waddr;

    logic                           cfg_we;
    logic [PROD_W-1:0]              prod;
    logic                           prod_ovf;
    logic [itcs_pkg::CODE_W-1:0]    q_step;
    logic [itcs_pkg::RADIX_W-1:0]   rem_step;
    logic                           last_digit;

    // APB
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_size_reg <= 7'd26;
            min_len_reg       <= 5'd1;
            max_len_reg       <= 5'd6;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                itcs_pkg::REG_ALPHABET_SIZE: alphabet_size_reg <= pwdata[6:0];
                itcs_pkg::REG_MIN_LEN:       min_len_reg       <= pwdata[4:0];
                itcs_pkg::REG_MAX_LEN:       max_len_reg       <= pwdata[4:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            itcs_pkg::REG_ALPHABET_SIZE: prdata = {25'd0, alphabet_size_reg};
            itcs_pkg::REG_MIN_LEN:       prdata = {27'd0, min_len_reg};
            itcs_pkg::REG_MAX_LEN:       prdata = {27'd0, max_len_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // shared multiplier: next power of the radix, overflow means "saturated"
    assign prod     = PROD_W'(pw_reg) * PROD_W'(b_reg);
    assign prod_ovf = |prod[PROD_W-1:itcs_pkg::CODE_W];

    // shared divider: DIV_BITS restoring steps; remainder stays below the radix
    always_comb
    begin
        logic [itcs_pkg::RADIX_W-1:0] t;
        logic [itcs_pkg::CODE_W-1:0]  q;
        q = r_reg;
        t = rem_reg;
        for (int i = 0; i < itcs_pkg::DIV_BITS; i++)
        begin
            t = {t[itcs_pkg::RADIX_W-2:0], q[itcs_pkg::CODE_W-1]};
            q = {q[itcs_pkg::CODE_W-2:0], 1'b0};
            if (t >= b_reg)
            begin
                t    = t - b_reg;
                q[0] = 1'b1;
            end
        end
        q_step   = q;
        rem_step = t;
    end

    assign last_digit = ({1'b0, ocnt_reg} + 5'd1) == len_reg;
    assign dig_waddr  = itcs_pkg::POS_W'(len_reg - 5'd1 - {1'b0, dcnt_reg});

    always_comb
    begin
        state_next    = state_reg;
        b_next        = b_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        l_next        = l_reg;
        len_next      = len_reg;
        r_next        = r_reg;
        pw_next       = pw_reg;
        big_next      = big_reg;
        err_next      = err_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        dcnt_next     = dcnt_reg;
        ocnt_next     = ocnt_reg;
        dig_we        = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (alphabet_size_reg < itcs_pkg::RADIX_MIN)
                        b_next = itcs_pkg::RADIX_MIN;
                    else if (alphabet_size_reg > itcs_pkg::RADIX_MAX)
                        b_next = itcs_pkg::RADIX_MAX;
                    else
                        b_next = alphabet_size_reg;
                    if (min_len_reg == 5'd0)
                        lo_next = 5'd1;
                    else if (min_len_reg > itcs_pkg::LEN_CAP)
                        lo_next = itcs_pkg::LEN_CAP;
                    else
                        lo_next = min_len_reg;
                    hi_next    = (max_len_reg > itcs_pkg::LEN_CAP) ? itcs_pkg::LEN_CAP
                                                                   : max_len_reg;
                    r_next     = s_tdata;
                    pw_next    = 64'd1;
                    big_next   = 1'b0;
                    err_next   = 1'b0;
                    l_next     = 5'd0;
                    state_next = ST_POW;
                end
            end

            // l_reg counts multiplications until pw = B^lo
            ST_POW:
            begin
                if (l_reg == lo_reg)
                    state_next = ST_LEN;
                else
                begin
                    if (!big_reg)
                    begin
                        if (prod_ovf)
                            big_next = 1'b1;
                        else
                            pw_next = prod[itcs_pkg::CODE_W-1:0];
                    end
                    l_next = l_reg + 5'd1;
                end
            end

            ST_LEN:
            begin
                if (l_reg > hi_reg)
                begin
                    err_next   = 1'b1;
                    len_next   = 5'd0;
                    ocnt_next  = '0;
                    state_next = ST_OUT;
                end
                else if (big_reg || r_reg < pw_reg)
                begin
                    len_next   = l_reg;
                    rem_next   = '0;
                    step_next  = '0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    r_next = r_reg - pw_reg;
                    if (prod_ovf)
                        big_next = 1'b1;
                    else
                        pw_next = prod[itcs_pkg::CODE_W-1:0];
                    l_next = l_reg + 5'd1;
                end
            end

            ST_DIV:
            begin
                r_next    = q_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (step_reg == itcs_pkg::STEP_W'(itcs_pkg::DIV_STEPS - 1))
                begin
                    dig_we   = 1'b1;
                    rem_next = '0;
                    if ({1'b0, dcnt_reg} + 5'd1 == len_reg)
                    begin
                        ocnt_next  = '0;
                        state_next = ST_OUT;
                    end
                    else
                        dcnt_next = dcnt_reg + 1'b1;
                end
            end

            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (err_reg)
                    begin
                        m_tdata_next = 16'd0;
                        m_tlast_next = 1'b1;
                        m_tuser_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        m_tdata_next = {1'b0, len_reg, ocnt_reg, digits[ocnt_reg]};
                        m_tlast_next = last_digit;
                        m_tuser_next = 1'b0;
                        if (last_digit)
                            state_next = ST_IDLE;
                        else
                            ocnt_next = ocnt_reg + 1'b1;
                    end
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            l_reg        <= '0;
            step_reg     <= '0;
            dcnt_reg     <= '0;
            ocnt_reg     <= '0;
            err_reg      <= 1'b0;
            big_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            l_reg        <= l_next;
            step_reg     <= step_next;
            dcnt_reg     <= dcnt_next;
            ocnt_reg     <= ocnt_next;
            err_reg      <= err_next;
            big_reg      <= big_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg       <= b_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        len_reg     <= len_next;
        r_reg       <= r_next;
        pw_reg      <= pw_next;
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_ff @(posedge clk)
    begin
        if (dig_we)
            digits[dig_waddr] <= rem_step[itcs_pkg::SYM_W-1:0];
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
